### src/wpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpa_pkg
// Shared types and constants of the worker pool allocator: default sizes,
// action and status codes, and the request/response bundle of the node table.
// ----------------------------------------------------------------------------
package wpa_pkg;

  localparam int WPA_MAX_WORKERS = 64;
  localparam int WPA_MAX_NODES   = 16;
  localparam int WPA_ID_BITS     = 16;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_TAKE  = 2'd1,
    ACT_GET   = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_e;

  // commands to the per-node free count table
  typedef enum logic [1:0] {
    NCMD_SCAN  = 2'd0,
    NCMD_INC   = 2'd1,
    NCMD_DEC   = 2'd2,
    NCMD_CLEAR = 2'd3
  } ncmd_e;

  typedef struct packed {
    logic  valid;
    ncmd_e op;
  } node_req_t;

  typedef struct packed {
    logic busy;
    logic nonzero;
  } node_rsp_t;

endpackage : wpa_pkg
`default_nettype wire

### src/wpa_node_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpa_node_table
// Free worker count per node, held in a synchronous memory. Scans for the
// node with the most free workers, bumps or drops one count, or sweeps the
// table to zero (also right after reset).
// ----------------------------------------------------------------------------
module wpa_node_table import wpa_pkg::*; #(
  parameter int MAX_WORKERS = WPA_MAX_WORKERS,
  parameter int MAX_NODES   = WPA_MAX_NODES,
  localparam int NODE_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
  localparam int CNT_W      = $clog2(MAX_WORKERS + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire node_req_t         req_i,
  input  wire logic [NODE_W-1:0] node_i,
  output      node_rsp_t         rsp_o,
  output      logic [NODE_W-1:0] best_node_o
);

  localparam logic [NODE_W-1:0] LAST = NODE_W'(MAX_NODES - 1);

  typedef enum logic [5:0] {
    N_IDLE  = 6'b000001,
    N_SCAN  = 6'b000010,
    N_DRAIN = 6'b000100,
    N_READ  = 6'b001000,
    N_WRITE = 6'b010000,
    N_CLEAR = 6'b100000
  } nstate_e;

  nstate_e           state_q, state_d;
  logic [NODE_W-1:0] addr_q, addr_d;
  logic              rvalid_q, rvalid_d;
  logic [CNT_W-1:0]  best_cnt_q, best_cnt_d;
  logic [NODE_W-1:0] best_node_q, best_node_d;

  logic [CNT_W-1:0]  cnt_mem [MAX_NODES];
  logic [CNT_W-1:0]  rd_q;
  logic [NODE_W-1:0] rd_idx_q;
  logic [NODE_W-1:0] node_q;
  logic              inc_q;

  logic              re, we;
  logic [NODE_W-1:0] raddr, waddr;
  logic [CNT_W-1:0]  wdata;

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    rvalid_d    = 1'b0;
    best_cnt_d  = best_cnt_q;
    best_node_d = best_node_q;
    re          = 1'b0;
    raddr       = addr_q;
    we          = 1'b0;
    waddr       = addr_q;
    wdata       = '0;

    // strict compare keeps the lowest node on ties
    if (rvalid_q && (rd_q > best_cnt_q)) begin
      best_cnt_d  = rd_q;
      best_node_d = rd_idx_q;
    end

    case (state_q)
      N_IDLE: begin
        if (req_i.valid) begin
          case (req_i.op)
            NCMD_SCAN: begin
              state_d     = N_SCAN;
              addr_d      = '0;
              best_cnt_d  = '0;
              best_node_d = '0;
            end
            NCMD_INC, NCMD_DEC: begin
              state_d = N_READ;
            end
            NCMD_CLEAR: begin
              state_d = N_CLEAR;
              addr_d  = '0;
            end
            default: ;
          endcase
        end
      end
      N_SCAN: begin
        re       = 1'b1;
        rvalid_d = 1'b1;
        addr_d   = NODE_W'(addr_q + 1'b1);
        if (addr_q == LAST) begin
          state_d = N_DRAIN;
        end
      end
      N_DRAIN: begin
        state_d = N_IDLE;
      end
      N_READ: begin
        re      = 1'b1;
        raddr   = node_q;
        state_d = N_WRITE;
      end
      N_WRITE: begin
        we      = 1'b1;
        waddr   = node_q;
        wdata   = inc_q ? CNT_W'(rd_q + 1'b1) : CNT_W'(rd_q - 1'b1);
        state_d = N_IDLE;
      end
      N_CLEAR: begin
        we     = 1'b1;
        addr_d = NODE_W'(addr_q + 1'b1);
        if (addr_q == LAST) begin
          state_d = N_IDLE;
        end
      end
      default: begin
        state_d = N_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= N_CLEAR;
      addr_q      <= '0;
      rvalid_q    <= 1'b0;
      best_cnt_q  <= '0;
      best_node_q <= '0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      rvalid_q    <= rvalid_d;
      best_cnt_q  <= best_cnt_d;
      best_node_q <= best_node_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == N_IDLE && req_i.valid) begin
      node_q <= node_i;
      inc_q  <= (req_i.op == NCMD_INC);
    end
    rd_idx_q <= raddr;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      cnt_mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= cnt_mem[raddr];
    end
  end

  assign rsp_o.busy    = (state_q != N_IDLE);
  assign rsp_o.nonzero = (best_cnt_q != '0);
  assign best_node_o   = best_node_q;

  a_req_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid |-> state_q == N_IDLE)
    else $error("node table command while busy");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == N_WRITE && !inc_q) |-> rd_q != '0)
    else $error("node free count underflow");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("node table state not one-hot");

endmodule : wpa_node_table
`default_nettype wire

### src/worker_pool_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// worker_pool_allocator
// Pool of free workers with put, take-best, get-by-id and clear commands.
// ----------------------------------------------------------------------------
// usage:
//   a command beat is accepted when start is high and busy is low; action_i
//   picks put, take, get or clear, with worker_id_i, node_id_i and
//   usage_count_i as operands. exactly one result beat follows per command,
//   shown for one cycle with done_o high; the receiver cannot stall it and
//   busy stays high until that cycle is over.
// steps (accept edge to done_o), one command at a time:
//   put            walk the slot memory, then, unless dup or full, store
//                  into the first free slot and bump the node count
//   get            walk the slot memory
//   take           walk the node count memory, then the slot memory (no slot
//                  walk when the pool is empty), free the slot, drop its count
//   clear          sweep the slot and node count memories side by side
//   the slot memory is walked one entry a cycle through its single read
//   port; take also walks the node count memory.
// reset: slot and node memories are swept to empty side by side; busy is
//   high meanwhile.
// ----------------------------------------------------------------------------
module worker_pool_allocator import wpa_pkg::*; #(
  parameter int MAX_WORKERS = WPA_MAX_WORKERS,
  parameter int MAX_NODES   = WPA_MAX_NODES,
  parameter int ID_BITS     = WPA_ID_BITS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [1:0]  action_i,
  input  wire logic [15:0] worker_id_i,
  input  wire logic [3:0]  node_id_i,
  input  wire logic [31:0] usage_count_i,
  output      logic        done_o,
  output      logic [1:0]  status_o,
  output      logic [15:0] found_worker_o,
  output      logic [3:0]  found_node_o,
  output      logic [31:0] found_usage_o,
  output      logic [6:0]  pool_count_o
);

  localparam int SLOT_W = $clog2(MAX_WORKERS);
  localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int CNT_W  = $clog2(MAX_WORKERS + 1);
  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(MAX_WORKERS - 1);

  typedef struct packed {
    logic               valid;
    logic [ID_BITS-1:0] worker;
    logic [NODE_W-1:0]  node;
    logic [31:0]        usage;
    logic [31:0]        order;
  } slot_t;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_NWAIT   = 9'b000000010,
    S_SCAN    = 9'b000000100,
    S_DRAIN   = 9'b000001000,
    S_FINISH  = 9'b000010000,
    S_UPDATE  = 9'b000100000,
    S_CLEAR   = 9'b001000000,
    S_CLRWAIT = 9'b010000000,
    S_RESP    = 9'b100000000
  } state_e;

  // node number reduced into range, one entry per input code
  logic [NODE_W-1:0] node_map [16];
  for (genvar g = 0; g < 16; g++) begin : g_node_map
    assign node_map[g] = NODE_W'(g % MAX_NODES);
  end

  // control state
  state_e            state_q, state_d;
  logic [SLOT_W-1:0] addr_q, addr_d;
  logic              rvalid_q, rvalid_d;
  logic              hit_q, hit_d;
  logic              free_q, free_d;
  logic              dup_q, dup_d;
  logic              clr_resp_q, clr_resp_d;
  logic [CNT_W-1:0]  pool_total_q, pool_total_d;
  logic [31:0]       next_order_q, next_order_d;

  // payload
  action_e           act_q, act_d;
  logic [ID_BITS-1:0] wid_q, wid_d;
  logic [NODE_W-1:0] node_q, node_d;
  logic [31:0]       usage_q, usage_d;
  slot_t             cap_q, cap_d;
  logic [SLOT_W-1:0] cap_idx_q, cap_idx_d;
  logic [31:0]       age_q, age_d;
  logic [SLOT_W-1:0] free_idx_q, free_idx_d;
  logic [NODE_W-1:0] best_node_q, best_node_d;
  status_e           status_q, status_d;
  logic [15:0]       out_worker_q, out_worker_d;
  logic [3:0]        out_node_q, out_node_d;
  logic [31:0]       out_usage_q, out_usage_d;

  // slot memory
  slot_t             slot_mem [MAX_WORKERS];
  slot_t             rd_q;
  logic [SLOT_W-1:0] rd_idx_q;
  logic              s_re, s_we;
  logic [SLOT_W-1:0] s_waddr;
  slot_t             s_wdata;

  // node table
  node_req_t         nreq;
  node_rsp_t         nrsp;
  logic [NODE_W-1:0] nreq_node;
  logic [NODE_W-1:0] nbest;

  logic [31:0]       rd_age;
  logic              id_eq;
  logic              better;

  wpa_node_table #(
    .MAX_WORKERS (MAX_WORKERS),
    .MAX_NODES   (MAX_NODES)
  ) u_node_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (nreq),
    .node_i      (nreq_node),
    .rsp_o       (nrsp),
    .best_node_o (nbest)
  );

  assign rd_age = next_order_q - rd_q.order;
  assign id_eq  = rd_q.valid && (rd_q.worker == wid_q);
  assign better = !hit_q || (rd_q.usage > cap_q.usage) ||
                  ((rd_q.usage == cap_q.usage) && (rd_age > age_q));

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    rvalid_d     = 1'b0;
    hit_d        = hit_q;
    free_d       = free_q;
    dup_d        = dup_q;
    clr_resp_d   = clr_resp_q;
    pool_total_d = pool_total_q;
    next_order_d = next_order_q;
    act_d        = act_q;
    wid_d        = wid_q;
    node_d       = node_q;
    usage_d      = usage_q;
    cap_d        = cap_q;
    cap_idx_d    = cap_idx_q;
    age_d        = age_q;
    free_idx_d   = free_idx_q;
    best_node_d  = best_node_q;
    status_d     = status_q;
    out_worker_d = out_worker_q;
    out_node_d   = out_node_q;
    out_usage_d  = out_usage_q;
    s_re         = 1'b0;
    s_we         = 1'b0;
    s_waddr      = addr_q;
    s_wdata      = '0;
    nreq.valid   = 1'b0;
    nreq.op      = NCMD_SCAN;
    nreq_node    = (act_q == ACT_PUT) ? node_q : best_node_q;

    // consume one slot read beat of a scan
    if (rvalid_q) begin
      case (act_q)
        ACT_PUT: begin
          if (id_eq) begin
            dup_d = 1'b1;
          end
          if (!rd_q.valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = rd_idx_q;
          end
        end
        ACT_GET: begin
          if (id_eq && !hit_q) begin
            hit_d = 1'b1;
            cap_d = rd_q;
          end
        end
        ACT_TAKE: begin
          if (rd_q.valid && (rd_q.node == best_node_q) && better) begin
            hit_d     = 1'b1;
            cap_d     = rd_q;
            cap_idx_d = rd_idx_q;
            age_d     = rd_age;
          end
        end
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          act_d        = action_e'(action_i);
          wid_d        = ID_BITS'(worker_id_i);
          node_d       = node_map[node_id_i];
          usage_d      = usage_count_i;
          addr_d       = '0;
          hit_d        = 1'b0;
          free_d       = 1'b0;
          dup_d        = 1'b0;
          status_d     = ST_OK;
          out_worker_d = '0;
          out_node_d   = '0;
          out_usage_d  = '0;
          case (action_e'(action_i))
            ACT_PUT, ACT_GET: begin
              state_d = S_SCAN;
            end
            ACT_TAKE: begin
              nreq.valid = 1'b1;
              nreq.op    = NCMD_SCAN;
              state_d    = S_NWAIT;
            end
            ACT_CLEAR: begin
              nreq.valid   = 1'b1;
              nreq.op      = NCMD_CLEAR;
              pool_total_d = '0;
              next_order_d = '0;
              clr_resp_d   = 1'b1;
              state_d      = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_NWAIT: begin
        if (!nrsp.busy) begin
          if (nrsp.nonzero) begin
            best_node_d = nbest;
            state_d     = S_SCAN;
          end else begin
            status_d = ST_MISS;
            state_d  = S_RESP;
          end
        end
      end
      S_SCAN: begin
        s_re     = 1'b1;
        rvalid_d = 1'b1;
        addr_d   = SLOT_W'(addr_q + 1'b1);
        if (addr_q == LAST) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        state_d = S_RESP;
        case (act_q)
          ACT_PUT: begin
            if (dup_q) begin
              status_d = ST_DUP;
            end else if (!free_q) begin
              status_d = ST_FULL;
            end else begin
              s_we           = 1'b1;
              s_waddr        = free_idx_q;
              s_wdata.valid  = 1'b1;
              s_wdata.worker = wid_q;
              s_wdata.node   = node_q;
              s_wdata.usage  = usage_q;
              s_wdata.order  = next_order_q;
              next_order_d   = next_order_q + 32'd1;
              pool_total_d   = CNT_W'(pool_total_q + 1'b1);
              nreq.valid     = 1'b1;
              nreq.op        = NCMD_INC;
              state_d        = S_UPDATE;
            end
          end
          ACT_GET, ACT_TAKE: begin
            if (hit_q) begin
              out_worker_d = 16'(cap_q.worker);
              out_node_d   = 4'(cap_q.node);
              out_usage_d  = cap_q.usage;
              if (act_q == ACT_TAKE) begin
                s_we          = 1'b1;
                s_waddr       = cap_idx_q;
                s_wdata       = cap_q;
                s_wdata.valid = 1'b0;
                pool_total_d  = CNT_W'(pool_total_q - 1'b1);
                nreq.valid    = 1'b1;
                nreq.op       = NCMD_DEC;
                state_d       = S_UPDATE;
              end
            end else begin
              status_d = ST_MISS;
            end
          end
          default: ;
        endcase
      end
      S_UPDATE: begin
        if (!nrsp.busy) begin
          state_d = S_RESP;
        end
      end
      S_CLEAR: begin
        s_we    = 1'b1;
        s_waddr = addr_q;
        addr_d  = SLOT_W'(addr_q + 1'b1);
        if (addr_q == LAST) begin
          state_d = S_CLRWAIT;
        end
      end
      S_CLRWAIT: begin
        if (!nrsp.busy) begin
          state_d    = clr_resp_q ? S_RESP : S_IDLE;
          clr_resp_d = 1'b0;
        end
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      addr_q       <= '0;
      rvalid_q     <= 1'b0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      dup_q        <= 1'b0;
      clr_resp_q   <= 1'b0;
      pool_total_q <= '0;
      next_order_q <= '0;
    end else begin
      state_q      <= state_d;
      addr_q       <= addr_d;
      rvalid_q     <= rvalid_d;
      hit_q        <= hit_d;
      free_q       <= free_d;
      dup_q        <= dup_d;
      clr_resp_q   <= clr_resp_d;
      pool_total_q <= pool_total_d;
      next_order_q <= next_order_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    wid_q        <= wid_d;
    node_q       <= node_d;
    usage_q      <= usage_d;
    cap_q        <= cap_d;
    cap_idx_q    <= cap_idx_d;
    age_q        <= age_d;
    free_idx_q   <= free_idx_d;
    best_node_q  <= best_node_d;
    status_q     <= status_d;
    out_worker_q <= out_worker_d;
    out_node_q   <= out_node_d;
    out_usage_q  <= out_usage_d;
    rd_idx_q     <= addr_q;
  end

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      slot_mem[s_waddr] <= s_wdata;
    end
    if (s_re) begin
      rd_q <= slot_mem[addr_q];
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign done_o         = (state_q == S_RESP);
  assign status_o       = status_q;
  assign found_worker_o = out_worker_q;
  assign found_node_o   = out_node_q;
  assign found_usage_o  = out_usage_q;

  always_comb begin
    if ({{(32 - CNT_W){1'b0}}, pool_total_q} > 32'd127) begin
      pool_count_o = 7'd127;
    end else begin
      pool_count_o = 7'(pool_total_q);
    end
  end

  a_single_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result beat longer than one cycle");

  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pool_total_q <= CNT_W'(MAX_WORKERS))
    else $error("pool count beyond table size");

  a_put_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && act_q == ACT_PUT && !dup_q && free_q) |=>
      pool_total_q == CNT_W'($past(pool_total_q) + 1'b1))
    else $error("stored put did not bump pool count");

endmodule : worker_pool_allocator
`default_nettype wire
